[design/lmsb_pkg.sv]
// ----------------------------------------------------------------------------
// lmsb_pkg
// Shared types and constants of the LED matrix sprite blit block.
// ----------------------------------------------------------------------------
package lmsb_pkg;

    // Default store geometry
    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Field widths
    localparam int ACT_W      = 3;
    localparam int POS_W      = 8;
    localparam int LIN_W      = 14;
    localparam int PIX_W      = 8;
    localparam int DIM_W      = 7;
    localparam int ORG_W      = 8;
    localparam int IDX_W      = 15;   // row * width + col, width and rows below 128
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_COL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_ROW    = 3'd4;

    // Configuration reset values
    localparam logic [DIM_W-1:0] RST_MATRIX_WIDTH  = 7'd64;
    localparam logic [DIM_W-1:0] RST_MATRIX_HEIGHT = 7'd64;
    localparam logic [DIM_W-1:0] RST_SPRITE_WIDTH  = 7'd8;
    localparam logic [ORG_W-1:0] RST_ORIGIN        = 8'd0;

    // Pixel value returned by an out-of-range read
    localparam logic [PIX_W-1:0] PIX_OUT_OF_RANGE = 8'hFF;

    // Highest sprite row count, it saturates there
    localparam logic [DIM_W-1:0] SPRITE_ROW_MAX = 7'd127;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE_XY  = 3'd0,
        ACT_READ_XY   = 3'd1,
        ACT_WRITE_LIN = 3'd2,
        ACT_READ_LIN  = 3'd3,
        ACT_BLIT      = 3'd4,
        ACT_CLEAR     = 3'd5
    } t_action;

    // What the back end does with a queued operation
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,   // no store access, result from data/ok
        KIND_WRITE = 2'd1,   // store write of data
        KIND_READ  = 2'd2,   // store read, result is the read data
        KIND_CLEAR = 2'd3    // sweep the whole store to zero
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [PIX_W-1:0] data;
        logic             ok;
    } t_op;

endpackage

[design/lmsb_ram.sv]
// ----------------------------------------------------------------------------
// lmsb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lmsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/lmsb_front.sv]
// ----------------------------------------------------------------------------
// lmsb_front
// Front end: configuration registers, bounds checks, address generation and
// sprite position tracking. Turns each accepted item into one queued operation.
// ----------------------------------------------------------------------------
module lmsb_front #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lmsb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lmsb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_accept,
    input  logic [lmsb_pkg::ACT_W-1:0]         i_action,
    input  logic [lmsb_pkg::POS_W-1:0]         i_pos_x,
    input  logic [lmsb_pkg::POS_W-1:0]         i_pos_y,
    input  logic [lmsb_pkg::LIN_W-1:0]         i_linear_index,
    input  logic [lmsb_pkg::PIX_W-1:0]         i_pixel_value,
    input  logic                               i_sprite_last,
    output lmsb_pkg::t_op                      o_op,
    output logic [$clog2(MAX_COLS*MAX_ROWS)-1:0] o_addr
);

    import lmsb_pkg::*;

    localparam int AW = $clog2(MAX_COLS * MAX_ROWS);

    // Configuration
    logic [DIM_W-1:0] r_matrix_width;
    logic [DIM_W-1:0] r_matrix_height;
    logic [DIM_W-1:0] r_sprite_width;
    logic [ORG_W-1:0] r_origin_col;
    logic [ORG_W-1:0] r_origin_row;

    // Blit progress
    logic [DIM_W-1:0] r_sprite_col, n_sprite_col;
    logic [DIM_W-1:0] r_sprite_row, n_sprite_row;
    logic             r_blit_stopped, n_blit_stopped;
    logic             r_sprite_nonzero, n_sprite_nonzero;

    t_action            act;
    logic [DIM_W-1:0]   eff_w, eff_h, sw;
    logic [ORG_W:0]     mc, mr;         // signed sprite pixel position
    logic               stop_now, blit_in, nz, val_nz;
    logic               xy_in, lin_in;
    logic [DIM_W-1:0]   row_term, col_term;
    logic [2*DIM_W-1:0] row_prod, area;
    logic [IDX_W-1:0]   idx_rc, idx_sel;
    logic [DIM_W:0]     col_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_width  <= RST_MATRIX_WIDTH;
            r_matrix_height <= RST_MATRIX_HEIGHT;
            r_sprite_width  <= RST_SPRITE_WIDTH;
            r_origin_col    <= RST_ORIGIN;
            r_origin_row    <= RST_ORIGIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MATRIX_WIDTH:  r_matrix_width  <= i_cfg_data[DIM_W-1:0];
                CFG_MATRIX_HEIGHT: r_matrix_height <= i_cfg_data[DIM_W-1:0];
                CFG_SPRITE_WIDTH:  r_sprite_width  <= i_cfg_data[DIM_W-1:0];
                CFG_ORIGIN_COL:    r_origin_col    <= i_cfg_data[ORG_W-1:0];
                CFG_ORIGIN_ROW:    r_origin_row    <= i_cfg_data[ORG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        act   = t_action'(i_action);
        eff_w = (int'(r_matrix_width) > MAX_COLS) ? DIM_W'(MAX_COLS) : r_matrix_width;
        eff_h = (int'(r_matrix_height) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : r_matrix_height;
        sw    = (r_sprite_width == '0) ? DIM_W'(1) : r_sprite_width;

        // sprite pixel position on the matrix
        mc = {r_origin_col[ORG_W-1], r_origin_col} + {2'b00, r_sprite_col};
        mr = {r_origin_row[ORG_W-1], r_origin_row} + {2'b00, r_sprite_row};

        stop_now = r_blit_stopped || ($signed(mr) >= $signed({2'b00, eff_h}));
        blit_in  = !stop_now && !mc[ORG_W] && ($signed(mc) < $signed({2'b00, eff_w}))
                   && !mr[ORG_W];
        val_nz   = (i_pixel_value != '0);
        nz       = r_sprite_nonzero || val_nz;

        xy_in  = !i_pos_x[POS_W-1] && (i_pos_x[DIM_W-1:0] < eff_w)
                 && !i_pos_y[POS_W-1] && (i_pos_y[DIM_W-1:0] < eff_h);
        area   = {{DIM_W{1'b0}}, eff_w} * {{DIM_W{1'b0}}, eff_h};
        lin_in = !i_linear_index[LIN_W-1]
                 && ({1'b0, i_linear_index[LIN_W-2:0]} < area);

        // one row-major address unit, shared by xy access and blit
        row_term = (act == ACT_BLIT) ? mr[DIM_W-1:0] : i_pos_y[DIM_W-1:0];
        col_term = (act == ACT_BLIT) ? mc[DIM_W-1:0] : i_pos_x[DIM_W-1:0];
        row_prod = {{DIM_W{1'b0}}, row_term} * {{DIM_W{1'b0}}, eff_w};
        idx_rc   = {1'b0, row_prod} + IDX_W'(col_term);
        idx_sel  = (act == ACT_WRITE_LIN || act == ACT_READ_LIN)
                   ? IDX_W'(i_linear_index[LIN_W-2:0]) : idx_rc;
        o_addr   = AW'(idx_sel);

        o_op.kind = KIND_NONE;
        o_op.data = '0;
        o_op.ok   = 1'b0;
        unique case (act)
            ACT_WRITE_XY: begin
                if (xy_in) begin
                    o_op.kind = KIND_WRITE;
                    o_op.data = i_pixel_value;
                    o_op.ok   = 1'b1;
                end
            end
            ACT_READ_XY: begin
                if (xy_in) o_op.kind = KIND_READ;
                else       o_op.data = PIX_OUT_OF_RANGE;
            end
            ACT_WRITE_LIN: begin
                if (lin_in) begin
                    o_op.kind = KIND_WRITE;
                    o_op.data = i_pixel_value;
                    o_op.ok   = 1'b1;
                end
            end
            ACT_READ_LIN: begin
                if (lin_in) o_op.kind = KIND_READ;
                else        o_op.data = PIX_OUT_OF_RANGE;
            end
            ACT_BLIT: begin
                // negative sprite pixel clears, positive writes, zero skips
                if (blit_in && val_nz) begin
                    o_op.kind = KIND_WRITE;
                    o_op.data = i_pixel_value[PIX_W-1] ? '0 : i_pixel_value;
                end
                o_op.ok = i_sprite_last && nz;
            end
            ACT_CLEAR: o_op.kind = KIND_CLEAR;
            default: ;
        endcase
    end

    // sprite raster position, wraps at the sprite width
    always_comb begin
        col_inc          = {1'b0, r_sprite_col} + 1'b1;
        n_sprite_col     = r_sprite_col;
        n_sprite_row     = r_sprite_row;
        n_blit_stopped   = r_blit_stopped;
        n_sprite_nonzero = r_sprite_nonzero;
        if (i_accept && act == ACT_BLIT) begin
            if (i_sprite_last) begin
                n_sprite_col     = '0;
                n_sprite_row     = '0;
                n_blit_stopped   = 1'b0;
                n_sprite_nonzero = 1'b0;
            end else begin
                n_blit_stopped   = stop_now;
                n_sprite_nonzero = nz;
                if (col_inc >= {1'b0, sw}) begin
                    n_sprite_col = '0;
                    if (r_sprite_row < SPRITE_ROW_MAX) n_sprite_row = r_sprite_row + 1'b1;
                end else begin
                    n_sprite_col = col_inc[DIM_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sprite_col     <= '0;
            r_sprite_row     <= '0;
            r_blit_stopped   <= 1'b0;
            r_sprite_nonzero <= 1'b0;
        end else begin
            r_sprite_col     <= n_sprite_col;
            r_sprite_row     <= n_sprite_row;
            r_blit_stopped   <= n_blit_stopped;
            r_sprite_nonzero <= n_sprite_nonzero;
        end
    end

endmodule

[design/lmsb_queue.sv]
// ----------------------------------------------------------------------------
// lmsb_queue
// Small register FIFO between front and back end.
// ----------------------------------------------------------------------------
module lmsb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_valid,
    output logic             o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_head, n_head;
    logic [PW-1:0]    r_tail, n_tail;
    logic [CW-1:0]    r_count, n_count;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_push) begin
            n_tail  = (r_tail == PW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
            n_count = n_count + 1'b1;
        end
        if (i_pop) begin
            n_head  = (r_head == PW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_count = n_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_data;
        end
    end

    assign o_data  = r_mem[r_head];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));

endmodule

[design/lmsb_back.sv]
// ----------------------------------------------------------------------------
// lmsb_back
// Back end: carries out store operations, sweeps the store clear, and drives
// the result ports.
// ----------------------------------------------------------------------------
module lmsb_back #(
    parameter int DEPTH = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    input  lmsb_pkg::t_op                   i_op,
    input  logic [$clog2(DEPTH)-1:0]        i_addr,
    output logic                            o_pop,
    output logic                            o_clearing,
    output logic                            o_valid,
    output logic [lmsb_pkg::PIX_W-1:0]      o_read_value,
    output logic                            o_ok
);

    import lmsb_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic             r_clr_active, n_clr_active;
    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    logic             r_res_valid, n_res_valid;
    logic             r_res_ram, n_res_ram;
    logic [PIX_W-1:0] r_res_value, n_res_value;
    logic             r_res_ok, n_res_ok;

    logic             we;
    logic [AW-1:0]    waddr;
    logic [PIX_W-1:0] wdata, rdata;

    lmsb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (i_addr),
        .o_rdata (rdata)
    );

    always_comb begin
        o_pop = i_q_valid && !r_clr_active;

        // the sweep owns the write port while it runs
        we    = r_clr_active || (o_pop && i_op.kind == KIND_WRITE);
        waddr = r_clr_active ? r_clr_addr : i_addr;
        wdata = r_clr_active ? '0 : i_op.data;

        n_res_valid = o_pop;
        n_res_ram   = (i_op.kind == KIND_READ);
        n_res_value = (i_op.kind == KIND_NONE) ? i_op.data : '0;
        n_res_ok    = i_op.ok;

        n_clr_active = r_clr_active;
        n_clr_addr   = r_clr_addr;
        if (r_clr_active) begin
            if (r_clr_addr == AW'(DEPTH - 1)) n_clr_active = 1'b0;
            else                              n_clr_addr   = r_clr_addr + 1'b1;
        end else if (o_pop && i_op.kind == KIND_CLEAR) begin
            n_clr_active = 1'b1;
            n_clr_addr   = '0;
        end
    end

    // reset starts a sweep: the store comes up zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_res_valid  <= 1'b0;
        end else begin
            r_clr_active <= n_clr_active;
            r_clr_addr   <= n_clr_addr;
            r_res_valid  <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_ram   <= n_res_ram;
        r_res_value <= n_res_value;
        r_res_ok    <= n_res_ok;
    end

    assign o_clearing   = r_clr_active;
    assign o_valid      = r_res_valid;
    assign o_read_value = !r_res_valid ? '0 : (r_res_ram ? rdata : r_res_value);
    assign o_ok         = r_res_valid && r_res_ok;

endmodule

[design/led_matrix_sprite_blit.sv]
// ----------------------------------------------------------------------------
// led_matrix_sprite_blit
// LED matrix frame buffer of signed byte pixels with xy and linear access,
// full clear, and a streamed sprite blit with clipping on all sides.
// ----------------------------------------------------------------------------
// An item is taken at a clock edge where start is high and busy is low; each
// item gives exactly one result, shown on o_read_value/o_ok for one cycle
// with o_valid high. The receiver cannot stall: it must take the result in
// that cycle. Pixel accesses and sprite pixels are taken one per cycle while
// no sweep runs; an item's result passes the queue and the result register
// and waits while the store is swept. A clear sweeps all MAX_COLS*MAX_ROWS
// pixels (4096 at the default size) one per cycle and holds the store port;
// items behind it wait in the two-entry queue and busy stays high for the
// sweep. The same sweep runs after reset, so busy is high after reset until
// it ends. Configuration writes land at once and may be done whenever no
// result is outstanding, also in the middle of a sprite.
// ----------------------------------------------------------------------------
module led_matrix_sprite_blit #(
    parameter int MAX_COLS = lmsb_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = lmsb_pkg::DEF_MAX_ROWS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [lmsb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lmsb_pkg::CFG_DATA_W-1:0] i_cfg_data,

    // command side
    input  logic                            start,
    output logic                            busy,
    input  logic [lmsb_pkg::ACT_W-1:0]      i_action,
    input  logic [lmsb_pkg::POS_W-1:0]      i_pos_x,
    input  logic [lmsb_pkg::POS_W-1:0]      i_pos_y,
    input  logic [lmsb_pkg::LIN_W-1:0]      i_linear_index,
    input  logic [lmsb_pkg::PIX_W-1:0]      i_pixel_value,
    input  logic                            i_sprite_last,

    // result side
    output logic                            o_valid,
    output logic [lmsb_pkg::PIX_W-1:0]      o_read_value,
    output logic                            o_ok
);

    import lmsb_pkg::*;

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int OPW   = $bits(t_op);
    localparam int QW    = AW + OPW;

    logic          accept;
    t_op           f_op, q_op;
    logic [AW-1:0] f_addr, q_addr;
    logic [QW-1:0] q_data;
    logic          q_valid, q_full, q_pop;
    logic          clearing;

    // Items are refused while the queue is full or the store is swept.
    assign busy   = q_full || clearing;
    assign accept = start && !busy;

    // Front: classifies the item, checks bounds, forms the store address and
    // steps the sprite raster position.
    lmsb_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_action       (i_action),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_linear_index (i_linear_index),
        .i_pixel_value  (i_pixel_value),
        .i_sprite_last  (i_sprite_last),
        .o_op           (f_op),
        .o_addr         (f_addr)
    );

    // Queue of operations in transfer order; the back end drains it in order,
    // so a read always sees every earlier write and clear.
    lmsb_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  ({f_addr, f_op}),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    assign q_op   = t_op'(q_data[OPW-1:0]);
    assign q_addr = q_data[OPW +: AW];

    // Back: one store access per cycle, clear sweep, result register.
    lmsb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_op         (q_op),
        .i_addr       (q_addr),
        .o_pop        (q_pop),
        .o_clearing   (clearing),
        .o_valid      (o_valid),
        .o_read_value (o_read_value),
        .o_ok         (o_ok)
    );

endmodule

[design/lmsb_checker.sv]
// ----------------------------------------------------------------------------
// lmsb_checker
// Port-level checks of the LED matrix sprite blit block.
// ----------------------------------------------------------------------------
module lmsb_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       busy,
    input logic                       o_valid,
    input logic [lmsb_pkg::PIX_W-1:0] o_read_value,
    input logic                       o_ok
);

    // reset starts the store sweep, so no item is taken right after it
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // a nonzero value only comes from a read, and reads never report ok
    a_read_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_read_value != '0) |-> !o_ok)
        else $error("ok set together with a read value");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> (!o_ok && o_read_value == '0))
        else $error("result ports active without strobe");

endmodule

bind led_matrix_sprite_blit lmsb_checker u_lmsb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_read_value (o_read_value),
    .o_ok         (o_ok)
);

[tb/blit_scoreboard_pkg.sv]
// ----------------------------------------------------------------------------
// blit_scoreboard_pkg
// Command and readout types, and a scoreboard that mirrors the frame buffer,
// the blit state and the geometry registers to predict every readout.
// ----------------------------------------------------------------------------
package blit_scoreboard_pkg;
    import lmsb_pkg::*;

    // Action codes with no function in the block
    localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd7;

    // Register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct {
        logic [ACT_W-1:0]        action;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [LIN_W-1:0] linear_index;
        logic signed [PIX_W-1:0] pixel_value;
        logic                    sprite_last;
    } pixel_cmd_t;

    typedef struct {
        logic [PIX_W-1:0] read_value;
        logic             ok;
    } readout_t;

    class blit_scoreboard;
        logic signed [PIX_W-1:0] frame [DEF_MAX_COLS*DEF_MAX_ROWS];
        int       cols_reg;
        int       rows_reg;
        int       spr_w_reg;
        int       org_col;
        int       org_row;
        int       spr_col;
        int       spr_row;
        bit       blit_halted;
        bit       spr_any;
        readout_t due_readouts[$];
        int       failures;

        function new();
            foreach (frame[i]) frame[i] = '0;
            cols_reg    = RST_MATRIX_WIDTH;
            rows_reg    = RST_MATRIX_HEIGHT;
            spr_w_reg   = RST_SPRITE_WIDTH;
            org_col     = $signed(RST_ORIGIN);
            org_row     = $signed(RST_ORIGIN);
            spr_col     = 0;
            spr_row     = 0;
            blit_halted = 1'b0;
            spr_any     = 1'b0;
            failures    = 0;
        endfunction

        // sizes above the store act as the store size
        function int eff_cols();
            return (cols_reg > DEF_MAX_COLS) ? DEF_MAX_COLS : cols_reg;
        endfunction

        function int eff_rows();
            return (rows_reg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows_reg;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MATRIX_WIDTH:  cols_reg  = data[DIM_W-1:0];
                CFG_MATRIX_HEIGHT: rows_reg  = data[DIM_W-1:0];
                CFG_SPRITE_WIDTH:  spr_w_reg = data[DIM_W-1:0];
                CFG_ORIGIN_COL:    org_col   = $signed(data);
                CFG_ORIGIN_ROW:    org_row   = $signed(data);
                default: ;
            endcase
        endfunction

        // Note an accepted command: update the mirror, queue its readout.
        function void accept_command(pixel_cmd_t c);
            readout_t r;
            int       w;
            int       h;
            int       px;
            int       py;
            int       li;
            int       val;
            int       mc;
            int       mr;
            int       sw;
            bit       inb;
            bit       nz;
            w   = eff_cols();
            h   = eff_rows();
            px  = c.pos_x;
            py  = c.pos_y;
            li  = c.linear_index;
            val = c.pixel_value;
            r.read_value = '0;
            r.ok         = 1'b0;
            case (c.action)
                ACT_WRITE_XY, ACT_READ_XY: begin
                    inb = px >= 0 && px < w && py >= 0 && py < h;
                    if (c.action == ACT_WRITE_XY) begin
                        if (inb) begin
                            frame[px + py * w] = c.pixel_value;
                            r.ok = 1'b1;
                        end
                    end else begin
                        r.read_value = inb ? frame[px + py * w] : PIX_OUT_OF_RANGE;
                    end
                end
                ACT_WRITE_LIN, ACT_READ_LIN: begin
                    inb = li >= 0 && li < w * h;
                    if (c.action == ACT_WRITE_LIN) begin
                        if (inb) begin
                            frame[li] = c.pixel_value;
                            r.ok = 1'b1;
                        end
                    end else begin
                        r.read_value = inb ? frame[li] : PIX_OUT_OF_RANGE;
                    end
                end
                ACT_BLIT: begin
                    sw = (spr_w_reg == 0) ? 1 : spr_w_reg;
                    mc = org_col + spr_col;
                    mr = org_row + spr_row;
                    nz = spr_any || val != 0;
                    if (!blit_halted && mr >= h) blit_halted = 1'b1;
                    if (!blit_halted && mc >= 0 && mc < w && mr >= 0) begin
                        if (val > 0) frame[mc + mr * w] = c.pixel_value;
                        else if (val < 0) frame[mc + mr * w] = '0;
                    end
                    if (c.sprite_last) begin
                        r.ok        = nz;
                        spr_col     = 0;
                        spr_row     = 0;
                        blit_halted = 1'b0;
                        spr_any     = 1'b0;
                    end else begin
                        spr_any = nz;
                        spr_col++;
                        if (spr_col >= sw) begin
                            spr_col = 0;
                            if (spr_row < SPRITE_ROW_MAX) spr_row++;
                        end
                    end
                end
                ACT_CLEAR: foreach (frame[i]) frame[i] = '0;
                default: ;
            endcase
            due_readouts.push_back(r);
        endfunction

        function void check_readout(logic [PIX_W-1:0] rd, logic ok);
            readout_t want;
            if (due_readouts.size() == 0) begin
                failures++;
                $display("%0t: unexpected result, expected none, actual read_value %0d ok %0b",
                         $time, $signed(rd), ok);
                return;
            end
            want = due_readouts.pop_front();
            if (rd !== want.read_value) begin
                failures++;
                $display("%0t: read_value mismatch, expected %0d, actual %0d",
                         $time, $signed(want.read_value), $signed(rd));
            end
            if (ok !== want.ok) begin
                failures++;
                $display("%0t: ok mismatch, expected %0b, actual %0b", $time, want.ok, ok);
            end
        endfunction
    endclass

endpackage

[tb/led_matrix_sprite_blit_test.sv]
// ----------------------------------------------------------------------------
// led_matrix_sprite_blit_test
// Self-checking bench for the sprite blit frame buffer: directed corner
// cases, then random phases of pixel access, sprites and clears under a
// range of geometry settings, each readout checked against a mirror model.
// ----------------------------------------------------------------------------
module led_matrix_sprite_blit_test;
    import lmsb_pkg::*;
    import blit_scoreboard_pkg::*;

    // store sweep after reset and on every clear
    localparam int SWEEP_CYCLES = DEF_MAX_COLS * DEF_MAX_ROWS;
    // cycles without any transfer before the run is declared hung
    localparam int STALL_LIMIT  = 4 * SWEEP_CYCLES + 2000;
    localparam int RANDOM_ITEMS = 1000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  start;
    logic                  busy;
    logic [ACT_W-1:0]      i_action;
    logic [POS_W-1:0]      i_pos_x;
    logic [POS_W-1:0]      i_pos_y;
    logic [LIN_W-1:0]      i_linear_index;
    logic [PIX_W-1:0]      i_pixel_value;
    logic                  i_sprite_last;
    logic                  o_valid;
    logic [PIX_W-1:0]      o_read_value;
    logic                  o_ok;

    blit_scoreboard sb;
    int             cmds_issued;
    int             stall_cycles;
    bit             steady;   // no sender gaps while set

    always #5 i_clk = ~i_clk;

    led_matrix_sprite_blit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_linear_index (i_linear_index),
        .i_pixel_value  (i_pixel_value),
        .i_sprite_last  (i_sprite_last),
        .o_valid        (o_valid),
        .o_read_value   (o_read_value),
        .o_ok           (o_ok)
    );

    // ------------------------------------------------------------------------
    // Result side: the block cannot be stalled, so every strobe is a transfer.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) sb.check_readout(o_read_value, o_ok);
    end

    // Watchdog: restarts on any transfer. The limit covers the reset sweep
    // and a clear sweep with the whole queue waiting behind it.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles < STALL_LIMIT) begin
            stall_cycles <= stall_cycles + 1;
        end else begin
            $display("** led_matrix_sprite_blit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------

    // All fields random, so every input bit toggles over the run.
    function automatic pixel_cmd_t rand_cmd(logic [ACT_W-1:0] act);
        pixel_cmd_t c;
        c.action       = act;
        c.pos_x        = $urandom;
        c.pos_y        = $urandom;
        c.linear_index = $urandom;
        c.pixel_value  = $urandom;
        c.sprite_last  = $urandom;
        return c;
    endfunction

    function automatic pixel_cmd_t make_cmd(logic [ACT_W-1:0] act, int x, int y, int li,
                                            int val, bit last);
        pixel_cmd_t c;
        c.action       = act;
        c.pos_x        = x;
        c.pos_y        = y;
        c.linear_index = li;
        c.pixel_value  = val;
        c.sprite_last  = last;
        return c;
    endfunction

    // Present one command and hold it until busy is low at a rising edge.
    // start is left high after the transfer so back-to-back commands need
    // only one assignment per step; callers lower it when the stream stops.
    // A one-cycle gap comes before about one command in five.
    task automatic send_cmd(input pixel_cmd_t c);
        if (!steady && $urandom_range(0, 99) < 19) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_action       <= c.action;
        i_pos_x        <= c.pos_x;
        i_pos_y        <= c.pos_y;
        i_linear_index <= c.linear_index;
        i_pixel_value  <= c.pixel_value;
        i_sprite_last  <= c.sprite_last;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.accept_command(c);
        cmds_issued++;
    endtask

    // Stop sending and wait for every outstanding readout.
    task automatic drain();
        start <= 1'b0;
        while (sb.due_readouts.size() != 0) @(posedge i_clk);
    endtask

    // Write enable is left high for the next write; caller lowers it.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_register(idx, data);
    endtask

    // Matrix or sprite size: bit 7 of the data is ignored by the block.
    function automatic logic [CFG_DATA_W-1:0] pick_dim(bit sprite);
        logic [CFG_DATA_W-1:0] d;
        int                    r;
        r = $urandom_range(0, 99);
        if (r < 8)       d = 64;
        else if (r < 12) d = 1;
        else if (r < 14) d = 0;
        else if (r < 17) d = $urandom_range(65, 127);
        else             d = sprite ? $urandom_range(2, 12) : $urandom_range(2, 64);
        d[CFG_DATA_W-1] = $urandom_range(0, 1);
        return d;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_origin(int span, int lead);
        case ($urandom_range(0, 9))
            0:       return -64;
            1:       return 64;
            2:       return $urandom_range(0, 1) ? -128 : 127;
            3:       return $urandom;
            default: return $urandom_range(0, span + lead + 4) - lead - 2;
        endcase
    endfunction

    // Geometry for one phase; the first four phases pin the extremes.
    task automatic load_geometry(input int phase);
        logic [CFG_DATA_W-1:0] mw;
        logic [CFG_DATA_W-1:0] mh;
        logic [CFG_DATA_W-1:0] sw;
        logic [CFG_DATA_W-1:0] oc;
        logic [CFG_DATA_W-1:0] orow;
        int                    ew;
        int                    eh;
        int                    es;
        case (phase)
            0: begin mw = 64;    mh = 64;  sw = 64; oc = -64;  orow = -64; end
            1: begin mw = 1;     mh = 1;   sw = 1;  oc = 64;   orow = 64;  end
            2: begin mw = 8'h80; mh = 127; sw = 0;  oc = -128; orow = 127; end
            3: begin mw = 64;    mh = 64;  sw = 1;  oc = 10;   orow = -64; end
            default: begin
                mw   = pick_dim(1'b0);
                mh   = pick_dim(1'b0);
                sw   = ($urandom_range(0, 9) < 8) ? pick_dim(1'b1) : pick_dim(1'b0);
                ew   = (mw[DIM_W-1:0] > DEF_MAX_COLS) ? DEF_MAX_COLS : mw[DIM_W-1:0];
                eh   = (mh[DIM_W-1:0] > DEF_MAX_ROWS) ? DEF_MAX_ROWS : mh[DIM_W-1:0];
                es   = (sw[DIM_W-1:0] == 0) ? 1 : sw[DIM_W-1:0];
                oc   = pick_origin(ew, es);
                orow = pick_origin(eh, 6);
            end
        endcase
        set_reg(CFG_MATRIX_WIDTH, mw);
        set_reg(CFG_MATRIX_HEIGHT, mh);
        set_reg(CFG_SPRITE_WIDTH, sw);
        set_reg(CFG_ORIGIN_COL, oc);
        set_reg(CFG_ORIGIN_ROW, orow);
        if (phase == 2 || $urandom_range(0, 4) == 0) set_reg(CFG_UNUSED, $urandom);
        i_cfg_we <= 1'b0;
    endtask

    // Pixel access by column/row: mostly in range, else just off an edge
    // or anywhere in the field.
    task automatic send_xy(input logic [ACT_W-1:0] act);
        pixel_cmd_t c;
        int         w;
        int         h;
        c = rand_cmd(act);
        w = sb.eff_cols();
        h = sb.eff_rows();
        if (w > 0 && h > 0 && $urandom_range(0, 99) < 80) begin
            c.pos_x = $urandom_range(0, w - 1);
            c.pos_y = $urandom_range(0, h - 1);
        end else begin
            case ($urandom_range(0, 4))
                0: c.pos_x = w;
                1: c.pos_x = -1;
                2: c.pos_y = h;
                3: c.pos_y = -1;
                default: ;
            endcase
        end
        send_cmd(c);
    endtask

    task automatic send_linear(input logic [ACT_W-1:0] act);
        pixel_cmd_t c;
        int         n;
        c = rand_cmd(act);
        n = sb.eff_cols() * sb.eff_rows();
        if (n > 0 && $urandom_range(0, 99) < 80) begin
            c.linear_index = $urandom_range(0, n - 1);
        end else begin
            case ($urandom_range(0, 2))
                0: c.linear_index = n;
                1: c.linear_index = -1;
                default: ;
            endcase
        end
        send_cmd(c);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)      return 0;
        else if (r < 45) return $urandom;
        else if (r < 70) return $urandom_range(1, 127);
        else             return -$urandom_range(1, 128);
    endfunction

    // One sprite in raster order. Most are whole; some end early or run
    // past their last row, some are all zero, and now and then a pixel
    // access is slipped in between sprite pixels.
    task automatic send_sprite();
        pixel_cmd_t c;
        int         sw;
        int         total;
        int         k;
        bit         quiet;
        sw    = (sb.spr_w_reg == 0) ? 1 : sb.spr_w_reg;
        total = sw * $urandom_range(1, (sw > 32) ? 2 : 6);
        if ($urandom_range(0, 9) == 0) total = $urandom_range(1, total + sw);
        quiet = ($urandom_range(0, 7) == 0);
        for (k = 0; k < total; k++) begin
            c             = rand_cmd(ACT_BLIT);
            c.pixel_value = quiet ? '0 : pick_pixel();
            c.sprite_last = (k == total - 1);
            send_cmd(c);
            if (k != total - 1 && $urandom_range(0, 29) == 0)
                send_xy($urandom_range(0, 1) ? ACT_READ_XY : ACT_WRITE_XY);
        end
    endtask

    // A tall one-column sprite: the row count runs into its ceiling, so
    // the last pixels keep landing on the bottom row.
    task automatic send_long_sprite();
        int k;
        for (k = 0; k < 140; k++)
            send_cmd(make_cmd(ACT_BLIT, 0, 0, 0, $urandom_range(1, 127), k == 139));
        send_cmd(make_cmd(ACT_READ_XY, 10, 63, 0, 0, 1'b0));
        send_cmd(make_cmd(ACT_READ_XY, 10, 0, 0, 0, 1'b0));
    endtask

    task automatic random_pick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)      send_sprite();
        else if (r < 56) send_xy(ACT_WRITE_XY);
        else if (r < 70) send_xy(ACT_READ_XY);
        else if (r < 80) send_linear(ACT_WRITE_LIN);
        else if (r < 92) send_linear(ACT_READ_LIN);
        else if (r < 95) send_cmd(rand_cmd(ACT_CLEAR));
        else             send_cmd(rand_cmd($urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int phase;
        int target;
        sb             = new();
        cmds_issued    = 0;
        steady         = 1'b0;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= '0;
        start          <= 1'b0;
        i_action       <= '0;
        i_pos_x        <= '0;
        i_pos_y        <= '0;
        i_linear_index <= '0;
        i_pixel_value  <= '0;
        i_sprite_last  <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset geometry (64x64, sprite width 8, origin 0).
        // The first transfer waits out the clearing sweep after reset.
        send_cmd(make_cmd(ACT_WRITE_XY, 0, 0, 0, 127, 1'b0));
        send_cmd(make_cmd(ACT_WRITE_XY, 63, 63, 0, -128, 1'b0));
        send_cmd(make_cmd(ACT_WRITE_XY, -128, 5, 0, 9, 1'b0));
        send_cmd(make_cmd(ACT_WRITE_XY, 5, 127, 0, 9, 1'b0));
        send_cmd(make_cmd(ACT_READ_XY, 0, 0, 0, 0, 1'b0));
        send_cmd(make_cmd(ACT_READ_XY, 63, 63, 0, 0, 1'b0));
        send_cmd(make_cmd(ACT_READ_XY, 64, 0, 0, 0, 1'b0));
        send_cmd(make_cmd(ACT_WRITE_LIN, 0, 0, 8191, 3, 1'b0));
        send_cmd(make_cmd(ACT_WRITE_LIN, 0, 0, -8192, 3, 1'b0));
        send_cmd(make_cmd(ACT_WRITE_LIN, 0, 0, 4095, 55, 1'b0));
        send_cmd(make_cmd(ACT_READ_LIN, 0, 0, 4095, 0, 1'b0));
        send_cmd(make_cmd(ACT_READ_LIN, 0, 0, 4096, 0, 1'b0));
        send_cmd(make_cmd(ACT_READ_LIN, 0, 0, 0, 0, 1'b0));
        // sprite: positive writes, negative clears, zero keeps
        send_cmd(make_cmd(ACT_BLIT, 0, 0, 0, 1, 1'b0));
        send_cmd(make_cmd(ACT_BLIT, 0, 0, 0, -5, 1'b0));
        send_cmd(make_cmd(ACT_BLIT, 0, 0, 0, 0, 1'b0));
        send_cmd(make_cmd(ACT_BLIT, 0, 0, 0, 9, 1'b1));
        // all-zero sprite reports ok low
        send_cmd(make_cmd(ACT_BLIT, 0, 0, 0, 0, 1'b1));
        send_cmd(make_cmd(ACT_SPARE_A, 1, 1, 1, 1, 1'b0));
        send_cmd(make_cmd(ACT_SPARE_B, 1, 1, 1, 1, 1'b1));
        send_cmd(make_cmd(ACT_CLEAR, 0, 0, 0, 0, 1'b0));
        send_cmd(make_cmd(ACT_READ_XY, 63, 63, 0, 0, 1'b0));
        send_cmd(make_cmd(ACT_READ_LIN, 0, 0, 4095, 0, 1'b0));

        // Random phases. Each one starts from an empty pipe, which also
        // makes the sender wait for every outstanding readout.
        cmds_issued = 0;
        phase       = 0;
        while (cmds_issued < RANDOM_ITEMS) begin
            drain();
            load_geometry(phase);
            steady = (phase >= 6 && phase < 9);
            if (phase == 3) begin
                send_long_sprite();
            end else begin
                target = cmds_issued + $urandom_range(30, 80);
                while (cmds_issued < target) random_pick();
            end
            phase++;
        end

        drain();
        repeat (16) @(posedge i_clk);
        if (sb.failures == 0 && sb.due_readouts.size() == 0) begin
            $display("** led_matrix_sprite_blit: PASSED **");
        end else begin
            $display("** led_matrix_sprite_blit: FAILED **");
        end
        $finish;
    end

endmodule
